// File: hw/rtl/isrt_pkg.sv
// Shared types and constants for the insertion sorter.
// Holds the store depth, field widths, the per-cell control struct and the
// controller status struct. Depends on nothing.
package isrt_pkg;

    // Capacity of the cell chain, in values.
    localparam int MAX_ITEMS = 64;
    // Width of the held value count, which must reach MAX_ITEMS itself.
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 32;

    // Controller states: collecting a set, or draining it to the output.
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // Commands that every cell of the chain sees in the same cycle.
    typedef struct packed {
        logic ins;    // insert the incoming value into the chain
        logic shift;  // move every value one cell toward the head
    } t_cell_ctl;

    // Handshake and result status from the controller.
    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic run_end;
        logic dropped;
    } t_status;

    // Flips the sign bit so that an unsigned compare orders signed values.
    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] bits);
        order_key = bits ^ {1'b1, {(VAL_W-1){1'b0}}};
    endfunction

endpackage

// File: hw/rtl/isrt_in_if.sv
// Input channel of the insertion sorter: valid, ready and one item.
// Depends on isrt_pkg for the value width.
interface isrt_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [isrt_pkg::VAL_W-1:0]  value;
    logic                               set_end;

    modport source(output valid, value, set_end, input ready);
    modport sink(input valid, value, set_end, output ready);
endinterface

// File: hw/rtl/isrt_out_if.sv
// Output channel of the insertion sorter: valid, ready and one result item.
// Depends on isrt_pkg for the value width.
interface isrt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [isrt_pkg::VAL_W-1:0]  sorted_value;
    logic                               run_end;
    logic                               overflowed;

    modport source(output valid, sorted_value, run_end, overflowed, input ready);
    modport sink(input valid, sorted_value, run_end, overflowed, output ready);
endinterface

// File: hw/rtl/isrt_cell.sv
// One cell of the sorting chain: holds one value and exchanges it with its
// neighbors. Depends on isrt_pkg for widths, the control struct and order_key.
module isrt_cell (
    input  logic                          i_clk,
    input  isrt_pkg::t_cell_ctl           i_ctl,
    input  logic [isrt_pkg::VAL_W-1:0]    i_new_val,
    input  logic                          i_occ,
    input  logic                          i_first_empty,
    input  logic [isrt_pkg::VAL_W-1:0]    i_left_val,
    input  logic                          i_left_gt,
    input  logic [isrt_pkg::VAL_W-1:0]    i_right_val,
    output logic [isrt_pkg::VAL_W-1:0]    o_val,
    output logic                          o_gt
);

    logic [isrt_pkg::VAL_W-1:0] r_val;
    logic [isrt_pkg::VAL_W-1:0] n_val;

    // A held value strictly above the new one moves up, so equal values keep
    // their arrival order.
    assign o_gt = i_occ &&
                  (isrt_pkg::order_key(r_val) > isrt_pkg::order_key(i_new_val));
    assign o_val = r_val;

    // On insert, a moving cell takes its left neighbor if that one also moves,
    // and the new value otherwise. On shift, it takes its right neighbor.
    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && (o_gt || i_first_empty)) begin
            n_val = i_left_gt ? i_left_val : i_new_val;
        end else if (i_ctl.shift) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: hw/rtl/isrt_ctrl.sv
// Controller of the insertion sorter: held count, overflow flag, fill and
// drain states. Depends on isrt_pkg for the state enum and structs.
module isrt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_set_end,
    input  logic                          i_out_ready,
    output isrt_pkg::t_cell_ctl           o_cell_ctl,
    output isrt_pkg::t_status             o_status,
    output logic [isrt_pkg::CNT_W-1:0]    o_count
);

    isrt_pkg::t_state              r_state;
    isrt_pkg::t_state              n_state;
    logic [isrt_pkg::CNT_W-1:0]    r_count;
    logic [isrt_pkg::CNT_W-1:0]    n_count;
    logic                          r_dropped;
    logic                          n_dropped;
    logic                          w_full;
    logic                          w_in_acc;
    logic                          w_out_acc;

    assign w_full = (r_count == isrt_pkg::CNT_W'(isrt_pkg::MAX_ITEMS));

    // State register, count and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= isrt_pkg::ST_FILL;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // Next state and handshake outputs.
    always_comb begin
        n_state              = r_state;
        n_count              = r_count;
        n_dropped            = r_dropped;
        o_cell_ctl           = '0;
        o_status.in_ready    = 1'b0;
        o_status.out_valid   = 1'b0;
        o_status.run_end     = (r_count == isrt_pkg::CNT_W'(1));
        o_status.dropped     = r_dropped;
        w_in_acc             = 1'b0;
        w_out_acc            = 1'b0;
        case (r_state)
            isrt_pkg::ST_FILL: begin
                o_status.in_ready = 1'b1;
                w_in_acc          = i_in_valid;
                if (w_in_acc) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        o_cell_ctl.ins = 1'b1;
                        n_count        = r_count + isrt_pkg::CNT_W'(1);
                    end
                    if (i_in_set_end) begin
                        n_state = isrt_pkg::ST_DRAIN;
                    end
                end
            end
            isrt_pkg::ST_DRAIN: begin
                o_status.out_valid = 1'b1;
                w_out_acc          = i_out_ready;
                if (w_out_acc) begin
                    o_cell_ctl.shift = 1'b1;
                    n_count          = r_count - isrt_pkg::CNT_W'(1);
                    if (o_status.run_end) begin
                        n_dropped = 1'b0;
                        n_state   = isrt_pkg::ST_FILL;
                    end
                end
            end
            default: begin
                n_state = isrt_pkg::ST_FILL;
            end
        endcase
    end

    assign o_count = r_count;

endmodule

// File: hw/rtl/insertion_sorter_core.sv
// Insertion sorter top level: a chain of MAX_ITEMS cells plus a controller.
// Fill: one item per cycle is accepted and stored in that cycle, or dropped if full.
// Drain: starts the cycle after the set_end item; one result per cycle (while the output is
// ready) from the chain head, N results for N held values, input held off until the last is taken.
// Reset (synchronous, active low) empties the chain and clears the overflow flag.
module insertion_sorter_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    isrt_in_if.sink        i_in,
    isrt_out_if.source     o_out
);

    isrt_pkg::t_cell_ctl           w_ctl;
    isrt_pkg::t_status             w_status;
    logic [isrt_pkg::CNT_W-1:0]    w_count;
    logic [isrt_pkg::VAL_W-1:0]    w_val [isrt_pkg::MAX_ITEMS];
    logic                          w_gt  [isrt_pkg::MAX_ITEMS];

    // Controller.
    isrt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_set_end (i_in.set_end),
        .i_out_ready  (o_out.ready),
        .o_cell_ctl   (w_ctl),
        .o_status     (w_status),
        .o_count      (w_count)
    );

    // Chain of cells; cell 0 holds the smallest value.
    for (genvar gi = 0; gi < isrt_pkg::MAX_ITEMS; gi++) begin : g_cell
        logic [isrt_pkg::VAL_W-1:0] w_left_val;
        logic                       w_left_gt;
        logic [isrt_pkg::VAL_W-1:0] w_right_val;

        if (gi == 0) begin : g_head
            assign w_left_val = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_body
            assign w_left_val = w_val[gi-1];
            assign w_left_gt  = w_gt[gi-1];
        end

        if (gi == isrt_pkg::MAX_ITEMS - 1) begin : g_tail
            assign w_right_val = '0;
        end else begin : g_inner
            assign w_right_val = w_val[gi+1];
        end

        isrt_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_new_val     (i_in.value),
            .i_occ         (isrt_pkg::CNT_W'(gi) < w_count),
            .i_first_empty (isrt_pkg::CNT_W'(gi) == w_count),
            .i_left_val    (w_left_val),
            .i_left_gt     (w_left_gt),
            .i_right_val   (w_right_val),
            .o_val         (w_val[gi]),
            .o_gt          (w_gt[gi])
        );
    end

    // Channel outputs.
    assign i_in.ready         = w_status.in_ready;
    assign o_out.valid        = w_status.out_valid;
    assign o_out.sorted_value = w_val[0];
    assign o_out.run_end      = w_status.run_end;
    assign o_out.overflowed   = w_status.dropped;

    // The block never takes an item while it offers a result.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while draining");

    // A drain never runs on an empty chain.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (w_count != '0))
        else $error("result offered with empty chain");

    // The count never exceeds the chain length.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= isrt_pkg::CNT_W'(isrt_pkg::MAX_ITEMS))
        else $error("held count beyond capacity");

    // Taking the last result of a set reopens the input with an empty chain.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.run_end) |=>
            (i_in.ready && (w_count == '0) && !o_out.overflowed))
        else $error("chain not emptied after last result");

endmodule

// File: test/insertion_sorter_core_test.sv
// Self-checking testbench for insertion_sorter_core: directed sets, then random sets.
// A shadow insertion store predicts every sorted result; the handshakes stall at random.
// Depends on isrt_pkg, isrt_in_if, isrt_out_if and the insertion_sorter_core RTL.
module insertion_sorter_core_test;

    // One sorted result as it leaves the block.
    typedef struct packed {
        logic signed [isrt_pkg::VAL_W-1:0] value;
        logic                              run_end;
        logic                              overflowed;
    } t_sorted;

    // One directed row: the item, and a typed result where it is obvious.
    typedef struct packed {
        logic signed [isrt_pkg::VAL_W-1:0] value;
        logic                              set_end;
        logic                              typed;
        t_sorted                           want;
    } t_stim_row;

    localparam int N_ROWS = 25;
    localparam logic signed [isrt_pkg::VAL_W-1:0] V_MIN =
        {1'b1, {(isrt_pkg::VAL_W-1){1'b0}}};
    localparam logic signed [isrt_pkg::VAL_W-1:0] V_MAX =
        {1'b0, {(isrt_pkg::VAL_W-1){1'b1}}};

    // Single-value sets first, then a descending set, a mixed set with
    // duplicates and extremes, alternating bit patterns and a short ascending set.
    t_stim_row dir_rows [N_ROWS] = '{
        '{V_MIN,        1'b1, 1'b1, '{V_MIN, 1'b1, 1'b0}},
        '{V_MAX,        1'b1, 1'b1, '{V_MAX, 1'b1, 1'b0}},
        '{32'sd0,       1'b1, 1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{-32'sd1,      1'b1, 1'b1, '{-32'sd1, 1'b1, 1'b0}},
        '{32'sd7,       1'b0, 1'b0, '0},
        '{32'sd6,       1'b0, 1'b0, '0},
        '{32'sd5,       1'b0, 1'b0, '0},
        '{32'sd4,       1'b0, 1'b0, '0},
        '{32'sd3,       1'b0, 1'b0, '0},
        '{32'sd2,       1'b0, 1'b0, '0},
        '{32'sd1,       1'b0, 1'b0, '0},
        '{32'sd0,       1'b1, 1'b0, '0},
        '{32'sd5,       1'b0, 1'b0, '0},
        '{V_MIN,        1'b0, 1'b0, '0},
        '{-32'sd3,      1'b0, 1'b0, '0},
        '{32'sd5,       1'b0, 1'b0, '0},
        '{V_MAX,        1'b0, 1'b0, '0},
        '{32'sd0,       1'b0, 1'b0, '0},
        '{-32'sd3,      1'b0, 1'b0, '0},
        '{V_MIN,        1'b0, 1'b0, '0},
        '{32'sd5,       1'b1, 1'b0, '0},
        '{32'sh5555_5555, 1'b0, 1'b0, '0},
        '{32'shAAAA_AAAA, 1'b1, 1'b0, '0},
        '{32'sd1,       1'b0, 1'b0, '0},
        '{32'sd2,       1'b1, 1'b0, '0}
    };

    // Capacity sets: exactly full, full with the set end dropped, and several drops.
    int cap_len [3] = '{isrt_pkg::MAX_ITEMS, isrt_pkg::MAX_ITEMS + 1,
                        isrt_pkg::MAX_ITEMS + 4};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    isrt_in_if  in_ch();
    isrt_out_if out_ch();

    insertion_sorter_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the sorter state.
    logic signed [isrt_pkg::VAL_W-1:0] shadow_store [isrt_pkg::MAX_ITEMS];
    int      shadow_count;
    bit      shadow_dropped;
    t_sorted pending_sorted [$];

    int n_errors;
    int n_items;
    int n_sets;
    int n_checked;
    int n_dropped_sets;
    bit steady;

    // Clock with an 8 unit period.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("insertion_sorter_core test failed");
        $finish;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what);
        n_errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Inserts one value into the shadow store; on a set end, queues the whole
    // sorted run and empties the store.
    task automatic predict_sorted_run(input logic signed [isrt_pkg::VAL_W-1:0] v,
                                      input logic last);
        int      pos;
        int      k;
        t_sorted r;
        if (shadow_count >= isrt_pkg::MAX_ITEMS) begin
            shadow_dropped = 1'b1;
        end else begin
            pos = shadow_count;
            // Equal values stay put, so later arrivals land after earlier ones.
            while (pos > 0 && shadow_store[pos-1] > v) begin
                shadow_store[pos] = shadow_store[pos-1];
                pos--;
            end
            shadow_store[pos] = v;
            shadow_count++;
        end
        if (last) begin
            for (k = 0; k < shadow_count; k++) begin
                r.value      = shadow_store[k];
                r.run_end    = (k == shadow_count - 1);
                r.overflowed = shadow_dropped;
                pending_sorted.push_back(r);
            end
            n_sets++;
            if (shadow_dropped) begin
                n_dropped_sets++;
            end
            shadow_count   = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    // Drives one item, with random gaps in front, and waits until it is taken.
    task automatic send_item(input logic signed [isrt_pkg::VAL_W-1:0] v, input logic last,
                             input logic typed, input t_sorted want);
        while (!steady && $urandom_range(0, 99) < 21) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.value   <= v;
        in_ch.set_end <= last;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        n_items++;
        predict_sorted_run(v, last);
        // A typed row replaces the single predicted result of its set.
        if (typed) begin
            void'(pending_sorted.pop_back());
            pending_sorted.push_back(want);
        end
    endtask

    // Holds the sender off until every queued result has come out.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_sorted.size() != 0);
    endtask

    // Mix of full-range values, a narrow band that makes ties, and extremes.
    function automatic logic signed [isrt_pkg::VAL_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            return $urandom;
        end else if (pick < 8) begin
            return $signed($urandom_range(0, 8)) - 4;
        end else if (pick == 8) begin
            case ($urandom_range(0, 3))
                0: return V_MIN;
                1: return V_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end else if ($urandom_range(0, 1) == 1) begin
            return V_MIN + $urandom_range(0, 3);
        end else begin
            return V_MAX - $urandom_range(0, 3);
        end
    endfunction

    task automatic send_random_set(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            send_item(rand_value(), i == len - 1, 1'b0, '0);
        end
    endtask

    // Compares one accepted result against the oldest queued one.
    task automatic check_result();
        t_sorted got;
        t_sorted want;
        got.value      = out_ch.sorted_value;
        got.run_end    = out_ch.run_end;
        got.overflowed = out_ch.overflowed;
        n_checked++;
        if (pending_sorted.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d", got.value));
        end else begin
            want = pending_sorted.pop_front();
            if (got.value !== want.value) begin
                report_mismatch($sformatf("sorted_value %0d, wanted %0d",
                                          got.value, want.value));
            end
            if (got.run_end !== want.run_end) begin
                report_mismatch($sformatf("run_end %b, wanted %b",
                                          got.run_end, want.run_end));
            end
            if (got.overflowed !== want.overflowed) begin
                report_mismatch($sformatf("overflowed %b, wanted %b",
                                          got.overflowed, want.overflowed));
            end
        end
    endtask

    // Result side: check what was taken at this edge, then pick the next ready.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_result();
            end
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 21);
        end
    end

    // Stimulus and end of run.
    initial begin
        int r;
        int s;
        int cap_idx;
        int guard;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        in_ch.set_end  = 1'b0;
        out_ch.ready   = 1'b0;
        steady         = 1'b0;
        shadow_count   = 0;
        shadow_dropped = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < N_ROWS; r++) begin
            send_item(dir_rows[r].value, dir_rows[r].set_end, dir_rows[r].typed,
                      dir_rows[r].want);
        end
        wait_for_results();

        // Random sets, mostly short; the capacity sets start from an empty block.
        s       = 0;
        cap_idx = 0;
        while (n_items < 410 || cap_idx < 3) begin
            steady = (n_items >= 150 && n_items < 260);
            if (s % 12 == 5 && cap_idx < 3) begin
                wait_for_results();
                send_random_set(cap_len[cap_idx]);
                cap_idx++;
            end else if ($urandom_range(0, 5) == 0) begin
                send_random_set($urandom_range(9, 20));
            end else begin
                send_random_set($urandom_range(1, 8));
            end
            s++;
        end
        steady = 1'b0;
        in_ch.valid <= 1'b0;

        guard = 0;
        while (pending_sorted.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (pending_sorted.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_sorted.size()));
        end

        $display("Sent %0d items in %0d sets, %0d of them with dropped values.",
                 n_items, n_sets, n_dropped_sets);
        $display("Checked %0d sorted results, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("insertion_sorter_core test passed");
        end else begin
            $display("insertion_sorter_core test failed");
        end
        $finish;
    end

endmodule
